/* hdl/psxad_pkg.sv */
// Shared types, constants and coefficient tables for the ADPCM decoder core.
// No dependencies; the core takes everything here by scoped names.
package psxad_pkg;

    // Sizing of the history, the filter coefficients and the accumulator
    localparam int HIST_W    = 32;
    localparam int COEF_W    = 9;
    localparam int FRAC_BITS = 6;
    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = HIST_W + COEF_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int Q_W       = ACC_W - FRAC_BITS;

    // Stereo interleave: channel flips every INTERLEAVE_BYTES input bytes
    localparam int INTERLEAVE_BYTES = 2048;
    localparam int BLK_W            = $clog2(2 * INTERLEAVE_BYTES);
    localparam logic [BLK_W-1:0] BLK_HALF = BLK_W'(INTERLEAVE_BYTES);
    localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(2 * INTERLEAVE_BYTES - 1);

    // Frame layout
    localparam logic [3:0] POS_HEADER = 4'd0;
    localparam logic [3:0] POS_FLAG   = 4'd1;
    localparam logic [7:0] FLAG_MUTE  = 8'h07;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_H1,
        ST_MUL_H2,
        ST_SUM,
        ST_DONE
    } state_t;

    // First filter coefficient, in 64ths
    function automatic logic signed [COEF_W-1:0] coef_k0(input logic [3:0] idx);
        logic signed [COEF_W-1:0] k;
        unique case (idx)
            4'd1:    k = 9'sd60;
            4'd2:    k = 9'sd115;
            4'd3:    k = 9'sd98;
            4'd4:    k = 9'sd122;
            4'd7:    k = 9'sd52;
            4'd8:    k = 9'sd55;
            4'd9:    k = 9'sd60;
            4'd13:   k = 9'sd2;
            4'd14:   k = 9'sd125;
            default: k = 9'sd0;
        endcase
        return k;
    endfunction

    // Second filter coefficient, in 64ths
    function automatic logic signed [COEF_W-1:0] coef_k1(input logic [3:0] idx);
        logic signed [COEF_W-1:0] k;
        unique case (idx)
            4'd2:    k = -9'sd52;
            4'd3:    k = -9'sd55;
            4'd4:    k = -9'sd60;
            4'd8:    k = -9'sd2;
            4'd9:    k = -9'sd125;
            4'd11:   k = -9'sd91;
            4'd13:   k = -9'sd216;
            4'd14:   k = -9'sd6;
            4'd15:   k = -9'sd151;
            default: k = 9'sd0;
        endcase
        return k;
    endfunction

endpackage

/* hdl/psx_adpcm_decoder_core.sv */
// PlayStation ADPCM decoder core: byte-in, sample-out, one shared multiplier.
// Depends on psxad_pkg for sizes, the sequencer state type and coefficients.
//
// The core takes the encoded stream one byte per item in 16-byte frames and
// returns one 16-bit sample per nibble (low nibble first, last_of_pair high
// on the second). Header and flag bytes are accepted without leaving idle and
// produce nothing. A data byte occupies the core from its acceptance through
// four sequencer steps per sample (multiply h1, multiply h2, sum, done): the
// single 32x9 multiplier forms the two history products of each sample in
// turn, and the second sample waits on the first's history. s_ready is low
// while a byte is in work; a stalled result holds the sequencer in its last
// step. In stereo mode the channel flips every 2048 bytes at frame starts.
module psx_adpcm_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_pcm_sample,
    output logic        m_channel,
    output logic        m_last_of_pair
);

    localparam int HW = psxad_pkg::HIST_W;
    localparam int PW = psxad_pkg::PROD_W;
    localparam int AW = psxad_pkg::ACC_W;
    localparam int QW = psxad_pkg::Q_W;
    localparam int FB = psxad_pkg::FRAC_BITS;
    localparam int SW = psxad_pkg::SAMPLE_W;
    localparam int BW = psxad_pkg::BLK_W;

    // Control and frame state
    psxad_pkg::state_t state_reg, state_next;
    logic          stereo_reg, stereo_next;
    logic [3:0]    frame_pos_reg, frame_pos_next;
    logic [BW-1:0] blk_pos_reg, blk_pos_next;
    logic [3:0]    pred_reg, pred_next;
    logic [3:0]    shift_reg, shift_next;
    logic          mute_reg, mute_next;
    logic          chan_reg, chan_next;
    logic          nib_sel_reg, nib_sel_next;
    logic          m_valid_reg, m_valid_next;

    // Histories per channel
    logic signed [HW-1:0] hist1_reg [2];
    logic signed [HW-1:0] hist2_reg [2];
    logic signed [HW-1:0] hist1_next [2];
    logic signed [HW-1:0] hist2_next [2];

    // Datapath payload
    logic [7:0]           byte_reg, byte_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [SW-1:0] m_sample_reg, m_sample_next;
    logic                 m_chan_reg, m_chan_next;
    logic                 m_last_reg, m_last_next;

    // Sequencer decode
    logic in_take;
    logic out_free;
    logic sample_done;
    logic mul_use_h2;

    // Datapath wires
    logic [3:0]                     nibble;
    logic signed [SW-1:0]           scaled;
    logic signed [HW-1:0]           mul_h;
    logic signed [psxad_pkg::COEF_W-1:0] mul_k;
    logic signed [PW-1:0]           mul_p;
    logic signed [QW-1:0]           q_floor;
    logic signed [QW-1:0]           q_trunc;
    logic [QW-HW:0]                 q_top;
    logic signed [HW-1:0]           q_sat;
    logic signed [HW-1:0]           q_hist;
    logic [HW-SW:0]                 h_top;
    logic signed [SW-1:0]           q_out;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            psxad_pkg::ST_IDLE: begin
                if (s_valid && frame_pos_reg != psxad_pkg::POS_HEADER
                        && frame_pos_reg != psxad_pkg::POS_FLAG) begin
                    state_next = psxad_pkg::ST_MUL_H1;
                end
            end
            psxad_pkg::ST_MUL_H1: state_next = psxad_pkg::ST_MUL_H2;
            psxad_pkg::ST_MUL_H2: state_next = psxad_pkg::ST_SUM;
            psxad_pkg::ST_SUM:    state_next = psxad_pkg::ST_DONE;
            psxad_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = nib_sel_reg ? psxad_pkg::ST_IDLE : psxad_pkg::ST_MUL_H1;
                end
            end
            default: state_next = psxad_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready     = 1'b0;
        sample_done = 1'b0;
        mul_use_h2  = 1'b0;
        unique case (state_reg)
            psxad_pkg::ST_IDLE:   s_ready     = 1'b1;
            psxad_pkg::ST_MUL_H2: mul_use_h2  = 1'b1;
            psxad_pkg::ST_DONE:   sample_done = out_free;
            default: ;
        endcase
    end

    assign in_take  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Sample scaling: nibble at the top of 16 bits, arithmetic shift right
    assign nibble = nib_sel_reg ? byte_reg[7:4] : byte_reg[3:0];
    assign scaled = $signed({nibble, 12'd0}) >>> shift_reg;

    // Shared multiplier: history times coefficient
    assign mul_h = mul_use_h2 ? hist2_reg[chan_reg] : hist1_reg[chan_reg];
    assign mul_k = mul_use_h2 ? psxad_pkg::coef_k1(pred_reg) : psxad_pkg::coef_k0(pred_reg);
    assign mul_p = mul_h * mul_k;

    // Divide by 64 toward zero, saturate to history width
    assign q_floor = acc_reg[AW-1:FB];
    assign q_trunc = q_floor + QW'(acc_reg[AW-1] && (|acc_reg[FB-1:0]));
    assign q_top   = q_trunc[QW-1:HW-1];
    always_comb begin
        if ((&q_top) || !(|q_top)) begin
            q_sat = q_trunc[HW-1:0];
        end else if (q_trunc[QW-1]) begin
            q_sat = {1'b1, {(HW-1){1'b0}}};
        end else begin
            q_sat = {1'b0, {(HW-1){1'b1}}};
        end
    end
    assign q_hist = mute_reg ? '0 : q_sat;

    // Clamp to the output sample width
    assign h_top = q_hist[HW-1:SW-1];
    always_comb begin
        if ((&h_top) || !(|h_top)) begin
            q_out = q_hist[SW-1:0];
        end else if (q_hist[HW-1]) begin
            q_out = {1'b1, {(SW-1){1'b0}}};
        end else begin
            q_out = {1'b0, {(SW-1){1'b1}}};
        end
    end

    // Register next values
    always_comb begin
        stereo_next    = cfg_we ? cfg_wdata : stereo_reg;
        frame_pos_next = frame_pos_reg;
        blk_pos_next   = blk_pos_reg;
        pred_next      = pred_reg;
        shift_next     = shift_reg;
        mute_next      = mute_reg;
        chan_next      = chan_reg;
        nib_sel_next   = nib_sel_reg;
        byte_next      = byte_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_sample_next  = m_sample_reg;
        m_chan_next    = m_chan_reg;
        m_last_next    = m_last_reg;
        hist1_next     = hist1_reg;
        hist2_next     = hist2_reg;

        // Take an item: header fields, flag, or start of a data byte
        if (in_take) begin
            frame_pos_next = frame_pos_reg + 4'd1;
            blk_pos_next   = (blk_pos_reg == psxad_pkg::BLK_LAST) ? '0 : blk_pos_reg + BW'(1);
            if (frame_pos_reg == psxad_pkg::POS_HEADER) begin
                pred_next  = s_data_byte[7:4];
                shift_next = s_data_byte[3:0];
                chan_next  = stereo_reg && (blk_pos_reg >= psxad_pkg::BLK_HALF);
            end else if (frame_pos_reg == psxad_pkg::POS_FLAG) begin
                mute_next = (s_data_byte >= psxad_pkg::FLAG_MUTE);
            end else begin
                byte_next    = s_data_byte;
                nib_sel_next = 1'b0;
            end
        end

        // Accumulate the scaled sample and both history products
        if (state_reg == psxad_pkg::ST_MUL_H1) begin
            prod_next = mul_p;
            acc_next  = {{(AW-SW-FB){scaled[SW-1]}}, scaled, {FB{1'b0}}};
        end
        if (state_reg == psxad_pkg::ST_MUL_H2) begin
            prod_next = mul_p;
        end
        if (state_reg == psxad_pkg::ST_MUL_H2 || state_reg == psxad_pkg::ST_SUM) begin
            acc_next = acc_reg + {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
        end

        // Finish a sample: advance history, load the output register
        if (sample_done) begin
            hist2_next[chan_reg] = hist1_reg[chan_reg];
            hist1_next[chan_reg] = q_hist;
            m_valid_next  = 1'b1;
            m_sample_next = q_out;
            m_chan_next   = chan_reg;
            m_last_next   = nib_sel_reg;
            nib_sel_next  = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= psxad_pkg::ST_IDLE;
            stereo_reg    <= 1'b1;
            frame_pos_reg <= '0;
            blk_pos_reg   <= '0;
            pred_reg      <= '0;
            shift_reg     <= '0;
            mute_reg      <= 1'b0;
            chan_reg      <= 1'b0;
            nib_sel_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            hist1_reg[0]  <= '0;
            hist1_reg[1]  <= '0;
            hist2_reg[0]  <= '0;
            hist2_reg[1]  <= '0;
        end else begin
            state_reg     <= state_next;
            stereo_reg    <= stereo_next;
            frame_pos_reg <= frame_pos_next;
            blk_pos_reg   <= blk_pos_next;
            pred_reg      <= pred_next;
            shift_reg     <= shift_next;
            mute_reg      <= mute_next;
            chan_reg      <= chan_next;
            nib_sel_reg   <= nib_sel_next;
            m_valid_reg   <= m_valid_next;
            hist1_reg     <= hist1_next;
            hist2_reg     <= hist2_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        m_sample_reg <= m_sample_next;
        m_chan_reg   <= m_chan_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_pcm_sample   = m_sample_reg;
    assign m_channel      = m_chan_reg;
    assign m_last_of_pair = m_last_reg;

endmodule
